### rtl/sym3inv_pkg.sv
package sym3inv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IW = 32;
  localparam int PW = 2 * IW;
  localparam int CW = PW + 2;
  localparam int CLW = CW / 2;
  localparam int CHW = CW - CLW;
  localparam int LW = IW + CLW + 1;
  localparam int HW = IW + CHW;
  localparam int TW = IW + CW;
  localparam int DW = TW + 2;
  localparam int UW = (2 * FRAC_BITS > IW) ? DW + 2 * FRAC_BITS + 1 : DW + IW + 1;
  localparam int QB = IW;
  localparam int FS = 6;
  localparam int DS = QB + 2;
  localparam int NS = FS + DS;
  localparam int NLANE = 9;
  localparam int NCOF = 6;
  localparam int NTERM = 12;
  localparam int NSUM = 4;

  localparam int TERM_COF [NTERM] = '{0, 3, 4, 0, 3, 4, 3, 1, 5, 4, 5, 2};

  typedef struct packed {
    logic signed [IW-1:0] m_xx;
    logic signed [IW-1:0] m_yy;
    logic signed [IW-1:0] m_zz;
    logic signed [IW-1:0] m_xy;
    logic signed [IW-1:0] m_xz;
    logic signed [IW-1:0] m_yz;
    logic signed [IW-1:0] vec_x;
    logic signed [IW-1:0] vec_y;
    logic signed [IW-1:0] vec_z;
  } sym3inv_in_t;

  typedef struct packed {
    logic signed [IW-1:0] inv_xx;
    logic signed [IW-1:0] inv_yy;
    logic signed [IW-1:0] inv_zz;
    logic signed [IW-1:0] inv_xy;
    logic signed [IW-1:0] inv_xz;
    logic signed [IW-1:0] inv_yz;
    logic signed [IW-1:0] sol_x;
    logic signed [IW-1:0] sol_y;
    logic signed [IW-1:0] sol_z;
    logic                 singular;
  } sym3inv_out_t;

endpackage

### rtl/sym3inv_if.sv
interface sym3inv_in_if;
  logic                      valid;
  logic                      ready;
  sym3inv_pkg::sym3inv_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sym3inv_out_if;
  logic                      valid;
  logic                      ready;
  sym3inv_pkg::sym3inv_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/sym3inv_div_lane.sv
module sym3inv_div_lane (
  input  logic                          clk_i,
  input  logic [sym3inv_pkg::DS-1:0]    en_i,
  input  logic [sym3inv_pkg::UW-1:0]    num_i,
  input  logic                          neg_i,
  input  logic [sym3inv_pkg::UW-1:0]    den_i [sym3inv_pkg::DS],
  output logic [sym3inv_pkg::IW-1:0]    res_o
);
  import sym3inv_pkg::*;

  logic [UW-1:0] rem_q [DS-1];
  logic [QB-1:0] q_q   [DS-1];
  logic          ovf_q [DS-1];
  logic          neg_q [DS-1];
  logic [IW-1:0] res_q;

  // overflow when the quotient needs more than QB bits
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= num_i;
      q_q[0]   <= '0;
      ovf_q[0] <= num_i >= (den_i[0] << QB);
      neg_q[0] <= neg_i;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_bit
    localparam int K = QB - j;
    logic [UW-1:0] trial;
    logic          ge;
    assign trial = den_i[j] << K;
    assign ge    = rem_q[j-1] >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= ge ? rem_q[j-1] - trial : rem_q[j-1];
        q_q[j]   <= q_q[j-1] | (QB'(ge) << K);
        ovf_q[j] <= ovf_q[j-1];
        neg_q[j] <= neg_q[j-1];
      end
    end
  end

  logic          rnd;
  logic [QB:0]   mag;
  logic          pos_sat, neg_sat;
  logic [IW-1:0] res_d;

  // round half away from zero, then saturate
  always_comb begin
    rnd     = {rem_q[DS-2], 1'b0} >= {1'b0, den_i[DS-1]};
    mag     = {1'b0, q_q[DS-2]} + (QB+1)'(rnd);
    pos_sat = ovf_q[DS-2] | mag[QB] | mag[QB-1];
    neg_sat = ovf_q[DS-2] | mag[QB] | (mag[QB-1] & (|mag[QB-2:0]));
    if (neg_q[DS-2]) begin
      res_d = neg_sat ? {1'b1, {(IW-1){1'b0}}} : IW'(-mag[IW-1:0]);
    end else begin
      res_d = pos_sat ? {1'b0, {(IW-1){1'b1}}} : mag[IW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[DS-1]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/sym3x3_inverse_and_solve.sv
// Symmetric 3x3 inverse and linear solve, signed fixed point.
// in_i (sink): one matrix (m_xx..m_yz) and right-hand vector (vec_x..vec_z)
// per transfer. out_o (source): six inverse entries, three solution
// components and the singular flag, one result per input, in order.
// Six stages form products, cofactors, split partial products, recombined
// halves, the determinant and adjugate-vector sums, and magnitudes; nine
// divider lanes then resolve one quotient bit per stage (32 stages) between
// an overflow check and a final round/saturate stage.
// Throughput: one item per cycle while out_o.ready stays high.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled receiver fills bubbles first; in_i.ready drops only when all 40
// stages hold items. Nothing is lost or repeated under stall.
// Reset clears the stage valid bits only; the pipe is empty after reset.
// A zero determinant gives singular = 1 and all other fields zero.
module sym3x3_inverse_and_solve (
  input  logic          clk_i,
  input  logic          rst_ni,
  sym3inv_in_if.sink    in_i,
  sym3inv_out_if.source out_o
);
  import sym3inv_pkg::*;

  logic [NS-1:0] v_q, en, v_in;

  assign en[NS-1] = ~v_q[NS-1] | out_o.ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end
  assign v_in       = {v_q[NS-2:0], in_i.valid};
  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // stage 0: 32x32 products
  logic signed [PW-1:0] p_d [NTERM];
  logic signed [PW-1:0] p_q [NTERM];
  logic signed [IW-1:0] a1_q, d1_q, e1_q;
  logic signed [IW-1:0] v1_q [3];

  always_comb begin
    p_d[0]  = in_i.data.m_yy * in_i.data.m_zz;
    p_d[1]  = in_i.data.m_yz * in_i.data.m_yz;
    p_d[2]  = in_i.data.m_zz * in_i.data.m_xx;
    p_d[3]  = in_i.data.m_xz * in_i.data.m_xz;
    p_d[4]  = in_i.data.m_xx * in_i.data.m_yy;
    p_d[5]  = in_i.data.m_xy * in_i.data.m_xy;
    p_d[6]  = in_i.data.m_xz * in_i.data.m_yz;
    p_d[7]  = in_i.data.m_zz * in_i.data.m_xy;
    p_d[8]  = in_i.data.m_xy * in_i.data.m_yz;
    p_d[9]  = in_i.data.m_yy * in_i.data.m_xz;
    p_d[10] = in_i.data.m_xz * in_i.data.m_xy;
    p_d[11] = in_i.data.m_xx * in_i.data.m_yz;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_q     <= p_d;
      a1_q    <= in_i.data.m_xx;
      d1_q    <= in_i.data.m_xy;
      e1_q    <= in_i.data.m_xz;
      v1_q[0] <= in_i.data.vec_x;
      v1_q[1] <= in_i.data.vec_y;
      v1_q[2] <= in_i.data.vec_z;
    end
  end

  // stage 1: cofactors
  logic signed [CW-1:0] cof2_q [NCOF];
  logic signed [IW-1:0] a2_q, d2_q, e2_q;
  logic signed [IW-1:0] v2_q [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < NCOF; i++) begin
        cof2_q[i] <= CW'(p_q[2*i]) - CW'(p_q[2*i+1]);
      end
      a2_q <= a1_q;
      d2_q <= d1_q;
      e2_q <= e1_q;
      v2_q <= v1_q;
    end
  end

  // stage 2: cofactor split into halves, partial products
  logic signed [IW-1:0] xop [NTERM];
  logic signed [LW-1:0] lo_d [NTERM];
  logic signed [HW-1:0] hi_d [NTERM];
  logic signed [LW-1:0] lo_q [NTERM];
  logic signed [HW-1:0] hi_q [NTERM];
  logic signed [CW-1:0] cof3_q [NCOF];

  always_comb begin
    xop[0] = a2_q;
    xop[1] = d2_q;
    xop[2] = e2_q;
    for (int t = 3; t < NTERM; t++) begin
      xop[t] = v2_q[(t-3) % 3];
    end
    for (int t = 0; t < NTERM; t++) begin
      lo_d[t] = xop[t] * $signed({1'b0, cof2_q[TERM_COF[t]][CLW-1:0]});
      hi_d[t] = xop[t] * $signed(cof2_q[TERM_COF[t]][CW-1:CLW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      cof3_q <= cof2_q;
    end
  end

  // stage 3: recombine halves
  logic signed [TW-1:0] term_q [NTERM];
  logic signed [CW-1:0] cof4_q [NCOF];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int t = 0; t < NTERM; t++) begin
        term_q[t] <= (TW'(hi_q[t]) <<< CLW) + TW'(lo_q[t]);
      end
      cof4_q <= cof3_q;
    end
  end

  // stage 4: determinant and adjugate * vector
  logic signed [DW-1:0] sum_q [NSUM];
  logic signed [CW-1:0] cof5_q [NCOF];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int g = 0; g < NSUM; g++) begin
        sum_q[g] <= DW'(term_q[3*g]) + DW'(term_q[3*g+1]) + DW'(term_q[3*g+2]);
      end
      cof5_q <= cof4_q;
    end
  end

  // stage 5: magnitudes and signs
  logic          dneg;
  logic [DW-1:0] dabs;
  logic [CW-1:0] cabs [NCOF];
  logic [DW-1:0] sabs [NSUM-1];
  logic [UW-1:0] nm_d [NLANE];
  logic          ng_d [NLANE];
  logic [UW-1:0] nm_q [NLANE];
  logic          ng_q [NLANE];
  logic [UW-1:0] dm5_q;
  logic          sg5_q;

  always_comb begin
    dneg = sum_q[0][DW-1];
    dabs = dneg ? DW'(-sum_q[0]) : DW'(sum_q[0]);
    for (int i = 0; i < NCOF; i++) begin
      cabs[i] = cof5_q[i][CW-1] ? CW'(-cof5_q[i]) : CW'(cof5_q[i]);
      nm_d[i] = UW'(cabs[i]) << (2 * FRAC_BITS);
      ng_d[i] = cof5_q[i][CW-1] ^ dneg;
    end
    for (int s = 0; s < NSUM - 1; s++) begin
      sabs[s]        = sum_q[s+1][DW-1] ? DW'(-sum_q[s+1]) : DW'(sum_q[s+1]);
      nm_d[NCOF + s] = UW'(sabs[s]) << FRAC_BITS;
      ng_d[NCOF + s] = sum_q[s+1][DW-1] ^ dneg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      nm_q  <= nm_d;
      ng_q  <= ng_d;
      dm5_q <= UW'(dabs);
      sg5_q <= sum_q[0] == '0;
    end
  end

  // divider stages: shared divisor and singular flag
  logic [UW-1:0] dd_q [DS-1];
  logic [UW-1:0] den_in [DS];
  logic [DS-1:0] sg_q;

  assign den_in[0] = dm5_q;
  for (genvar j = 1; j < DS; j++) begin : g_den
    assign den_in[j] = dd_q[j-1];
  end

  always_ff @(posedge clk_i) begin
    if (en[FS]) begin
      sg_q[0] <= sg5_q;
    end
    for (int j = 1; j < DS; j++) begin
      if (en[FS+j]) begin
        sg_q[j] <= sg_q[j-1];
      end
    end
    for (int j = 0; j < DS - 1; j++) begin
      if (en[FS+j]) begin
        dd_q[j] <= den_in[j];
      end
    end
  end

  logic [IW-1:0] res [NLANE];

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    sym3inv_div_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en[NS-1:FS]),
      .num_i (nm_q[l]),
      .neg_i (ng_q[l]),
      .den_i (den_in),
      .res_o (res[l])
    );
  end

  logic sg;
  assign sg = sg_q[DS-1];

  assign out_o.valid         = v_q[NS-1];
  assign out_o.data.inv_xx   = sg ? '0 : res[0];
  assign out_o.data.inv_yy   = sg ? '0 : res[1];
  assign out_o.data.inv_zz   = sg ? '0 : res[2];
  assign out_o.data.inv_xy   = sg ? '0 : res[3];
  assign out_o.data.inv_xz   = sg ? '0 : res[4];
  assign out_o.data.inv_yz   = sg ? '0 : res[5];
  assign out_o.data.sol_x    = sg ? '0 : res[6];
  assign out_o.data.sol_y    = sg ? '0 : res[7];
  assign out_o.data.sol_z    = sg ? '0 : res[8];
  assign out_o.data.singular = sg;

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready && (&v_q)))
    else $error("input blocked while pipe has room");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((in_i.valid && in_i.ready) == (out_o.valid && out_o.ready))
      |=> $countones(v_q) == $past($countones(v_q)))
    else $error("item lost or duplicated in pipe");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.singular) |->
      (out_o.data.inv_xx == '0 && out_o.data.inv_yz == '0 && out_o.data.sol_z == '0))
    else $error("singular result with nonzero payload");

endmodule
